FILE: rtl/core/tscc_pkg.sv
package tscc_pkg;

    localparam int PID_COUNT = 8192;

    localparam int PID_W   = 13;
    localparam int CC_W    = 4;
    localparam int TOTAL_W = 32;
    localparam int ENTRY_W = CC_W + 1;
    localparam int IDX_W   = $clog2(PID_COUNT);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PID_COUNT - 1);
    localparam logic [PID_W:0]   PID_LIMIT = (PID_W + 1)'(PID_COUNT);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        ST_NOT_RECORDED = 3'd0,
        ST_FIRST_SEEN   = 3'd1,
        ST_IN_ORDER     = 3'd2,
        ST_DUPLICATE    = 3'd3,
        ST_CONT_ERROR   = 3'd4
    } status_t;

endpackage

FILE: rtl/core/ts_continuity_counter_checker.sv
// Transport-stream continuity counter checker.
// Input channel (s_*): one packet header per transfer (PID, continuity
// counter, payload, null, transport error and discontinuity flags).
// Result channel (m_*): one verdict per header, in order: fit flag, status,
// previous counter, inferred missing packets, duplicate and error totals.
// A per-PID table (valid bit + last counter) sits in a single-port-read,
// single-port-write RAM. Stage 1 reads the entry, stage 2 judges the header
// and writes the entry back; the previous write is forwarded so a header on
// the same PID right behind another sees the fresh value.
// Throughput: one header per cycle while the receiver takes results, set by
// the one RAM read and one RAM write per header. The header and its entry are
// registered at the transfer (RAM read), then the verdict in the output register.
// Reset: the totals clear, then a clearing pass writes every table entry,
// one per cycle, all PID_COUNT (8192) of them, while s_ready is low.
// When the receiver stalls, the result is held in the output register, one
// more header waits in the judge stage, and s_ready drops.
module ts_continuity_counter_checker
    import tscc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PID_W-1:0]   s_pid,
    input  logic [CC_W-1:0]    s_cont_count,
    input  logic               s_payload_present,
    input  logic               s_null_packet,
    input  logic               s_error_flag,
    input  logic               s_discont_flag,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_fits_expected,
    output logic [2:0]         m_status,
    output logic               m_prev_valid,
    output logic [CC_W-1:0]    m_prev_count,
    output logic               m_missing_valid,
    output logic [CC_W-1:0]    m_missing_count,
    output logic [TOTAL_W-1:0] m_duplicate_total,
    output logic [TOTAL_W-1:0] m_error_total
);

    // clearing pass
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // judge stage
    logic             st1_valid_reg;
    logic [PID_W-1:0] st1_pid_reg;
    logic [CC_W-1:0]  st1_cc_reg;
    logic             st1_payload_reg;
    logic             st1_null_reg;
    logic             st1_err_reg;
    logic             st1_disc_reg;

    // last table write, for forwarding
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic [TOTAL_W-1:0] dup_reg, dup_next;
    logic [TOTAL_W-1:0] err_reg, err_next;

    logic               m_valid_reg;
    logic               fits_reg;
    status_t            status_reg;
    logic               prev_valid_reg;
    logic [CC_W-1:0]    prev_count_reg;
    logic               miss_valid_reg;
    logic [CC_W-1:0]    miss_count_reg;

    logic               s_xfer;
    logic               advance;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry;

    logic             in_table;
    logic             seen;
    logic             record;
    logic             tbl_write;
    logic [CC_W-1:0]  prev;
    logic [CC_W-1:0]  expected;
    logic [CC_W-1:0]  delta;
    logic             fits;
    status_t          status;
    logic             miss_valid;
    logic [CC_W-1:0]  miss_count;

    assign advance = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_busy_reg && (!st1_valid_reg || advance);
    assign s_xfer  = s_valid && s_ready;

    tscc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PID_COUNT)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (s_xfer),
        .raddr(s_pid[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    // judge
    always_comb begin
        entry = (fwd_valid_reg && fwd_idx_reg == st1_pid_reg[IDX_W-1:0])
                ? fwd_data_reg : ram_rdata;
        in_table = {1'b0, st1_pid_reg} < PID_LIMIT;
        seen     = in_table && entry[CC_W];
        prev     = seen ? entry[CC_W-1:0] : '0;
        expected = prev + CC_W'(1);
        delta    = st1_cc_reg - prev;
        record   = !st1_null_reg && !st1_err_reg && !st1_disc_reg;

        if (st1_null_reg) begin
            fits = 1'b1;
        end else if (st1_err_reg || st1_disc_reg) begin
            fits = 1'b0;
        end else if (!seen) begin
            fits = 1'b1;
        end else if (!st1_payload_reg) begin
            fits = st1_cc_reg == prev;
        end else begin
            fits = st1_cc_reg == expected;
        end

        miss_valid = !st1_null_reg && seen && st1_payload_reg && delta != '0;
        miss_count = miss_valid ? delta - CC_W'(1) : '0;

        dup_next  = dup_reg;
        err_next  = err_reg;
        status    = ST_NOT_RECORDED;
        tbl_write = record && in_table;
        if (tbl_write) begin
            if (!seen) begin
                status = ST_FIRST_SEEN;
            end else if (st1_payload_reg && st1_cc_reg == prev) begin
                status = ST_DUPLICATE;
            end else if (st1_payload_reg ? st1_cc_reg != expected
                                         : st1_cc_reg != prev) begin
                status = ST_CONT_ERROR;
            end else begin
                status = ST_IN_ORDER;
            end
        end
        if (status == ST_DUPLICATE && dup_reg != TOTAL_MAX) begin
            dup_next = dup_reg + TOTAL_W'(1);
        end
        if (status == ST_CONT_ERROR && err_reg != TOTAL_MAX) begin
            err_next = err_reg + TOTAL_W'(1);
        end

        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = advance && tbl_write;
            ram_waddr = st1_pid_reg[IDX_W-1:0];
            ram_wdata = {1'b1, st1_cc_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            st1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            dup_reg       <= '0;
            err_reg       <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s_xfer) begin
                st1_valid_reg <= 1'b1;
            end else if (advance) begin
                st1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                dup_reg     <= dup_next;
                err_reg     <= err_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance && tbl_write) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            st1_pid_reg     <= s_pid;
            st1_cc_reg      <= s_cont_count;
            st1_payload_reg <= s_payload_present;
            st1_null_reg    <= s_null_packet;
            st1_err_reg     <= s_error_flag;
            st1_disc_reg    <= s_discont_flag;
        end
        if (advance && tbl_write) begin
            fwd_idx_reg  <= st1_pid_reg[IDX_W-1:0];
            fwd_data_reg <= {1'b1, st1_cc_reg};
        end
        if (advance) begin
            fits_reg       <= fits;
            status_reg     <= status;
            prev_valid_reg <= !st1_null_reg && seen;
            prev_count_reg <= st1_null_reg ? '0 : prev;
            miss_valid_reg <= miss_valid;
            miss_count_reg <= miss_count;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fits_expected   = fits_reg;
    assign m_status          = status_reg;
    assign m_prev_valid      = prev_valid_reg;
    assign m_prev_count      = prev_count_reg;
    assign m_missing_valid   = miss_valid_reg;
    assign m_missing_count   = miss_count_reg;
    assign m_duplicate_total = dup_reg;
    assign m_error_total     = err_reg;

`ifndef SYNTHESIS
    // no header may enter while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready && !st1_valid_reg)
        else $error("header accepted during clearing pass");

    a_dup_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status == ST_DUPLICATE && dup_reg != TOTAL_MAX)
        |=> dup_reg == $past(dup_reg) + TOTAL_W'(1))
        else $error("duplicate total did not advance");

    a_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status != ST_CONT_ERROR) |=> $stable(err_reg))
        else $error("error total changed without a continuity error");

    a_no_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_prev_valid) |-> m_prev_count == '0 && !m_missing_valid)
        else $error("previous counter reported without a stored entry");
`endif

endmodule

FILE: rtl/core/tscc_ram.sv
module tscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: test/ts_continuity_counter_checker_test.sv
`timescale 1ns / 1ps

import tscc_pkg::*;

typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic             payload;
    logic             is_null;
    logic             tei;
    logic             disc;
} ts_header_t;

typedef struct packed {
    logic               fits;
    status_t            status;
    logic               prev_valid;
    logic [CC_W-1:0]    prev_count;
    logic               missing_valid;
    logic [CC_W-1:0]    lost_count;
    logic [TOTAL_W-1:0] dup_total;
    logic [TOTAL_W-1:0] err_total;
} cc_verdict_t;

class continuity_scoreboard;
    bit               pid_seen[PID_COUNT];
    bit [CC_W-1:0]    pid_last_cc[PID_COUNT];
    bit [TOTAL_W-1:0] dup_total;
    bit [TOTAL_W-1:0] err_total;
    cc_verdict_t      pending_verdicts[$];
    int               fails;
    int               noted;
    int               checked;
    int               status_hits[5];

    function new();
        dup_total = '0;
        err_total = '0;
        fails = 0;
        noted = 0;
        checked = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Works out the verdict for one accepted header and updates the PID table.
    function void note_header(ts_header_t h);
        cc_verdict_t   v;
        bit            in_tbl;
        bit            seen;
        bit            keep;
        bit [CC_W-1:0] prev;
        bit [CC_W-1:0] nxt;
        bit [CC_W-1:0] delta;
        v = '0;
        v.status = ST_NOT_RECORDED;
        in_tbl = h.pid < PID_COUNT;
        seen = in_tbl && pid_seen[h.pid];
        prev = seen ? pid_last_cc[h.pid] : '0;
        nxt = prev + 1'b1;
        keep = !h.is_null && !h.tei && !h.disc;

        if (h.is_null) begin
            v.fits = 1'b1;
        end else if (h.tei || h.disc) begin
            v.fits = 1'b0;
        end else if (!seen) begin
            v.fits = 1'b1;
        end else if (!h.payload) begin
            v.fits = (h.cc == prev);
        end else begin
            v.fits = (h.cc == nxt);
        end

        if (!h.is_null && seen) begin
            v.prev_valid = 1'b1;
            v.prev_count = prev;
            if (h.payload) begin
                delta = h.cc - prev;
                if (delta != 0) begin
                    v.missing_valid = 1'b1;
                    v.lost_count = delta - 1'b1;
                end
            end
        end

        if (keep && in_tbl) begin
            if (!seen) begin
                v.status = ST_FIRST_SEEN;
            end else if (h.payload && h.cc == prev) begin
                v.status = ST_DUPLICATE;
                if (dup_total != TOTAL_MAX) dup_total = dup_total + 1'b1;
            end else if ((h.payload && h.cc != nxt) || (!h.payload && h.cc != prev)) begin
                v.status = ST_CONT_ERROR;
                if (err_total != TOTAL_MAX) err_total = err_total + 1'b1;
            end else begin
                v.status = ST_IN_ORDER;
            end
            pid_seen[h.pid] = 1'b1;
            pid_last_cc[h.pid] = h.cc;
        end

        v.dup_total = dup_total;
        v.err_total = err_total;
        status_hits[int'(v.status)]++;
        noted++;
        pending_verdicts.push_back(v);
    endfunction

    function void report_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    function void check_verdict(cc_verdict_t got);
        cc_verdict_t want;
        if (pending_verdicts.size() == 0) begin
            $display("%0t: result transfer with nothing pending", $time);
            fails++;
            return;
        end
        want = pending_verdicts.pop_front();
        checked++;
        report_field("fits_expected", TOTAL_W'(want.fits), TOTAL_W'(got.fits));
        report_field("status", TOTAL_W'(want.status), TOTAL_W'(got.status));
        report_field("prev_valid", TOTAL_W'(want.prev_valid), TOTAL_W'(got.prev_valid));
        report_field("prev_count", TOTAL_W'(want.prev_count), TOTAL_W'(got.prev_count));
        report_field("missing_valid", TOTAL_W'(want.missing_valid),
                     TOTAL_W'(got.missing_valid));
        report_field("lost_count", TOTAL_W'(want.lost_count), TOTAL_W'(got.lost_count));
        report_field("duplicate_total", want.dup_total, got.dup_total);
        report_field("error_total", want.err_total, got.err_total);
    endfunction
endclass

module ts_continuity_counter_checker_test;

    // clearing pass after reset writes all 8192 table entries with no transfer
    localparam int STUCK_LIMIT  = 40000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int POOL_SIZE    = 12;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [PID_W-1:0]   s_pid = '0;
    logic [CC_W-1:0]    s_cont_count = '0;
    logic               s_payload_present = 1'b0;
    logic               s_null_packet = 1'b0;
    logic               s_error_flag = 1'b0;
    logic               s_discont_flag = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_fits_expected;
    logic [2:0]         m_status;
    logic               m_prev_valid;
    logic [CC_W-1:0]    m_prev_count;
    logic               m_missing_valid;
    logic [CC_W-1:0]    m_missing_count;
    logic [TOTAL_W-1:0] m_duplicate_total;
    logic [TOTAL_W-1:0] m_error_total;

    continuity_scoreboard board;
    bit                   idle_on = 1'b1;
    int                   stall_left = 0;
    int                   stuck_cycles = 0;
    logic [PID_W-1:0]     pid_pool[POOL_SIZE];
    logic [CC_W-1:0]      next_cc[POOL_SIZE];

    ts_continuity_counter_checker uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pid             (s_pid),
        .s_cont_count      (s_cont_count),
        .s_payload_present (s_payload_present),
        .s_null_packet     (s_null_packet),
        .s_error_flag      (s_error_flag),
        .s_discont_flag    (s_discont_flag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fits_expected   (m_fits_expected),
        .m_status          (m_status),
        .m_prev_valid      (m_prev_valid),
        .m_prev_count      (m_prev_count),
        .m_missing_valid   (m_missing_valid),
        .m_missing_count   (m_missing_count),
        .m_duplicate_total (m_duplicate_total),
        .m_error_total     (m_error_total)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic ts_header_t mk_header(logic [PID_W-1:0] pid, logic [CC_W-1:0] cc,
                                             logic pl, logic nl, logic te, logic di);
        ts_header_t h;
        h.pid = pid;
        h.cc = cc;
        h.payload = pl;
        h.is_null = nl;
        h.tei = te;
        h.disc = di;
        return h;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_header(input ts_header_t h);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pid <= h.pid;
        s_cont_count <= h.cc;
        s_payload_present <= h.payload;
        s_null_packet <= h.is_null;
        s_error_flag <= h.tei;
        s_discont_flag <= h.disc;
        do @(posedge aclk); while (!s_ready);
        board.note_header(h);
        @(negedge aclk);
    endtask

    // Result side back-pressure, drawn at random while idle_on is set
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        cc_verdict_t got;
        if (aresetn && m_valid && m_ready) begin
            got.fits = m_fits_expected;
            got.status = status_t'(m_status);
            got.prev_valid = m_prev_valid;
            got.prev_count = m_prev_count;
            got.missing_valid = m_missing_valid;
            got.lost_count = m_missing_count;
            got.dup_total = m_duplicate_total;
            got.err_total = m_error_total;
            board.check_verdict(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        ts_header_t h;
        int         slot;
        int         roll;
        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // PID 0: first seen, in order, duplicate, counter repeat without payload,
        // bad counter without payload, jump, wrap, unrecorded packets, then in order again
        send_header(mk_header(13'd0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd5, 1'b0, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd15, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd3, 1'b1, 1'b1, 1'b0, 1'b0));
        send_header(mk_header(13'd0, 4'd7, 1'b1, 1'b0, 1'b1, 1'b0));
        send_header(mk_header(13'd0, 4'd9, 1'b1, 1'b0, 1'b0, 1'b1));
        send_header(mk_header(13'd0, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0));
        // top PID: first seen without payload, duplicate, delta 15, all flags, TEI, in order
        send_header(mk_header(13'h1fff, 4'd15, 1'b0, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'h1fff, 4'd15, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'h1fff, 4'd14, 1'b1, 1'b0, 1'b0, 1'b0));
        send_header(mk_header(13'h1fff, 4'd15, 1'b1, 1'b1, 1'b1, 1'b1));
        send_header(mk_header(13'h1fff, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_header(mk_header(13'h1fff, 4'd15, 1'b1, 1'b0, 1'b0, 1'b0));
        // unseen PIDs hit by null and errored packets before their first record
        send_header(mk_header(13'h1555, 4'd10, 1'b0, 1'b1, 1'b0, 1'b0));
        send_header(mk_header(13'h0aaa, 4'd4, 1'b1, 1'b0, 1'b1, 1'b0));
        send_header(mk_header(13'h0aaa, 4'd4, 1'b1, 1'b0, 1'b0, 1'b0));

        pid_pool[0] = '0;
        pid_pool[1] = '1;
        next_cc[0] = 4'd2;
        next_cc[1] = 4'd0;
        for (int p = 2; p < POOL_SIZE; p++) begin
            pid_pool[p] = PID_W'($urandom_range(0, PID_COUNT - 1));
            next_cc[p] = CC_W'($urandom_range(0, 15));
        end

        // Mostly well-formed streams on a small PID pool so entries get reused
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on <= (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 250) % 3 != 2);
            slot = $urandom_range(0, POOL_SIZE - 1);
            roll = $urandom_range(0, 99);
            h = mk_header(pid_pool[slot], next_cc[slot], 1'b1, 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 9) == 0) h.pid = PID_W'($urandom_range(0, PID_COUNT - 1));
            if (roll >= 70 && roll < 78) begin
                h.payload = 1'b0;
                h.cc = next_cc[slot] - 1'b1;
            end else if (roll >= 78 && roll < 84) begin
                h.cc = next_cc[slot] - 1'b1;
            end else if (roll >= 84) begin
                h.cc = CC_W'($urandom_range(0, 15));
                h.payload = ($urandom_range(0, 1) == 1);
                h.is_null = ($urandom_range(0, 3) == 0);
                h.tei = ($urandom_range(0, 3) == 0);
                h.disc = ($urandom_range(0, 3) == 0);
            end
            if (!h.is_null && !h.tei && !h.disc && h.pid == pid_pool[slot])
                next_cc[slot] = h.cc + 1'b1;
            send_header(h);
        end
        s_valid <= 1'b0;

        while (board.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Checked %0d of %0d headers: %0d first seen, %0d in order, %0d duplicates,",
                 board.checked, board.noted, board.status_hits[ST_FIRST_SEEN],
                 board.status_hits[ST_IN_ORDER], board.status_hits[ST_DUPLICATE]);
        $display("  %0d continuity errors, %0d not recorded, under random stalls on both sides",
                 board.status_hits[ST_CONT_ERROR], board.status_hits[ST_NOT_RECORDED]);
        if (board.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
